FILE: src/prm_pkg.sv
// ----------------------------------------------------------------------------
// prm_pkg
// shared constants, register indexes and elaboration-time table builders for
// the pixel rotation address mapper
// ----------------------------------------------------------------------------
package prm_pkg;

    // default parameter values
    localparam int DEF_MAX_DIM        = 1024;
    localparam int DEF_TRIG_FRAC_BITS = 15;

    // fixed field widths
    localparam int ANGLE_W   = 9;
    localparam int CFG_IDX_W = 2;
    localparam int DEG_W     = 10;
    localparam int QIDX_W    = 7;
    localparam int QUARTER_N = 91;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE   = 2'd3;

    // angle landmarks in degrees
    localparam logic [DEG_W-1:0] DEG_90  = 10'd90;
    localparam logic [DEG_W-1:0] DEG_180 = 10'd180;
    localparam logic [DEG_W-1:0] DEG_270 = 10'd270;
    localparam logic [DEG_W-1:0] DEG_360 = 10'd360;

    // pi in q2.30 for the sine table
    localparam longint PI_Q30 = 64'sd3373259426;

    // sin(k deg) for k in 0..90, scaled by 2^frac, rounded
    // eight taylor terms after the first, divisors (2n)(2n+1)
    function automatic longint quarter_sine(input int k, input int frac);
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint r;
        longint one;
        begin
            one = longint'(1) <<< frac;
            if (k == 0)
                return 0;
            if (k >= 90)
                return one;
            x    = (longint'(k) * PI_Q30 + 90) / 180;
            x2   = (x * x) >>> 30;
            term = ((x * x2) >>> 30) / 6;
            sum  = x - term;
            term = ((term * x2) >>> 30) / 20;
            sum  = sum + term;
            term = ((term * x2) >>> 30) / 42;
            sum  = sum - term;
            term = ((term * x2) >>> 30) / 72;
            sum  = sum + term;
            term = ((term * x2) >>> 30) / 110;
            sum  = sum - term;
            term = ((term * x2) >>> 30) / 156;
            sum  = sum + term;
            term = ((term * x2) >>> 30) / 210;
            sum  = sum - term;
            term = ((term * x2) >>> 30) / 272;
            sum  = sum + term;
            if (sum < 0)
                sum = 0;
            r = (sum + (longint'(1) <<< (29 - frac))) >>> (30 - frac);
            if (r > one)
                r = one;
            return r;
        end
    endfunction

    // integer square root by bit-wise search
    function automatic longint isqrt(input longint v);
        longint r;
        longint t;
        begin
            r = 0;
            for (int b = 31; b >= 0; b--)
            begin
                t = r | (longint'(1) <<< b);
                if (t * t <= v)
                    r = t;
            end
            return r;
        end
    endfunction

endpackage

FILE: src/prm_trig_rom.sv
// ----------------------------------------------------------------------------
// prm_trig_rom
// reduces the rotation angle modulo 360 and looks up registered sine and
// cosine from a quarter-wave table folded by quadrant
// ----------------------------------------------------------------------------
module prm_trig_rom
    import prm_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [ANGLE_W-1:0]               angle_deg,
    output logic signed [TRIG_FRAC_BITS+1:0] sin_val,
    output logic signed [TRIG_FRAC_BITS+1:0] cos_val
);

    localparam int QW = TRIG_FRAC_BITS + 1;
    localparam int TW = TRIG_FRAC_BITS + 2;

    typedef struct packed {
        logic              neg;
        logic [QIDX_W-1:0] idx;
    } fold_t;

    logic [QW-1:0]        qrom [QUARTER_N];
    logic [DEG_W-1:0]     ang_sin;
    logic [DEG_W-1:0]     ang_cos_raw;
    logic [DEG_W-1:0]     ang_cos;
    fold_t                fold_sin;
    fold_t                fold_cos;
    logic signed [TW-1:0] sin_next;
    logic signed [TW-1:0] cos_next;
    logic signed [TW-1:0] sin_reg;
    logic signed [TW-1:0] cos_reg;

    // quarter-wave table built at elaboration
    for (genvar k = 0; k < QUARTER_N; k++)
    begin : g_rom
        localparam longint QV = quarter_sine(k, TRIG_FRAC_BITS);
        assign qrom[k] = QW'(QV);
    end

    function automatic fold_t fold_angle(input logic [DEG_W-1:0] a);
        fold_t f;
        begin
            priority if (a <= DEG_90)
            begin
                f.neg = 1'b0;
                f.idx = a[QIDX_W-1:0];
            end
            else if (a <= DEG_180)
            begin
                f.neg = 1'b0;
                f.idx = QIDX_W'(DEG_180 - a);
            end
            else if (a <= DEG_270)
            begin
                f.neg = 1'b1;
                f.idx = QIDX_W'(a - DEG_180);
            end
            else
            begin
                f.neg = 1'b1;
                f.idx = QIDX_W'(DEG_360 - a);
            end
            return f;
        end
    endfunction

    always_comb
    begin
        ang_sin     = (DEG_W'(angle_deg) >= DEG_360) ? DEG_W'(angle_deg) - DEG_360
                                                     : DEG_W'(angle_deg);
        ang_cos_raw = ang_sin + DEG_90;
        ang_cos     = (ang_cos_raw >= DEG_360) ? ang_cos_raw - DEG_360 : ang_cos_raw;
        fold_sin    = fold_angle(ang_sin);
        fold_cos    = fold_angle(ang_cos);
        sin_next    = fold_sin.neg ? -$signed({1'b0, qrom[fold_sin.idx]})
                                   :  $signed({1'b0, qrom[fold_sin.idx]});
        cos_next    = fold_cos.neg ? -$signed({1'b0, qrom[fold_cos.idx]})
                                   :  $signed({1'b0, qrom[fold_cos.idx]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sin_reg <= '0;
            cos_reg <= TW'(longint'(1) <<< TRIG_FRAC_BITS);
        end
        else
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

FILE: src/pixel_rotation_address_mapper.sv
// ----------------------------------------------------------------------------
// pixel_rotation_address_mapper
// rotates each source pixel position about the image center and places it in
// a square output frame, passing the color bytes through
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ---------------------------------
//  in        sink       in_valid / in_stall  src_col src_row blue green red in
//  out       source     out_valid/out_stall  dst_col dst_row in_frame b/g/r out
//  cfg       sink       cfg_we               cfg_index cfg_data
//
// one request per clock sustained while out_stall is low; every request gives
// one result once it is accepted (pipeline of four register stages: offset,
// multiply, sum, truncate and bound check)
// stages hand over individually, so bubbles close up while the output stalls;
// in_stall rises only when every stage holds a request and out_stall is high
// reset clears the valid bits and loads the register defaults (angle 0, full
// width and height, frame side equal to the integer diagonal)
// sine and cosine are registered from the angle register after an angle write
// ----------------------------------------------------------------------------
module pixel_rotation_address_mapper
    import prm_pkg::*;
#(
    parameter int MAX_DIM        = DEF_MAX_DIM,
    parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [((($clog2(MAX_DIM*3/2+1)) > ANGLE_W) ?
                   ($clog2(MAX_DIM*3/2+1)) : ANGLE_W)-1:0] cfg_data,
    // source pixel requests
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [$clog2(MAX_DIM)-1:0]    src_col,
    input  logic [$clog2(MAX_DIM)-1:0]    src_row,
    input  logic [7:0]                    blue_in,
    input  logic [7:0]                    green_in,
    input  logic [7:0]                    red_in,
    // destination results
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [$clog2(MAX_DIM*3/2+1)-1:0] dst_col,
    output logic [$clog2(MAX_DIM*3/2+1)-1:0] dst_row,
    output logic                          in_frame,
    output logic [7:0]                    blue_out,
    output logic [7:0]                    green_out,
    output logic [7:0]                    red_out
);

    // coordinate and dimension widths
    localparam int CW     = $clog2(MAX_DIM);             // source position
    localparam int DW     = $clog2(MAX_DIM + 1);         // width and height
    localparam int SW     = $clog2(MAX_DIM * 3 / 2 + 1); // frame side
    localparam int F      = TRIG_FRAC_BITS;
    localparam int TW     = F + 2;                       // signed trig value
    localparam int DCW    = CW + 1;                      // signed offset
    localparam int PROD_W = DCW + TW;
    localparam int SUM_W  = PROD_W + 1;
    localparam int IW     = SUM_W - F;                   // truncated position
    localparam longint SIDE_RST = isqrt(2 * longint'(MAX_DIM) * longint'(MAX_DIM));

    // configuration registers
    logic [ANGLE_W-1:0] angle_reg;
    logic [DW-1:0]      width_reg;
    logic [DW-1:0]      height_reg;
    logic [SW-1:0]      side_reg;

    // trig values for the current angle
    logic signed [TW-1:0] sin_val;
    logic signed [TW-1:0] cos_val;

    // stage handover
    logic ready1;
    logic ready2;
    logic ready3;
    logic ready4;

    // stage 1: offsets from the image center
    logic [DW-1:0]         width_clamp;
    logic [DW-1:0]         height_clamp;
    logic signed [DCW-1:0] dc_next;
    logic signed [DCW-1:0] dr_next;
    logic                  v1_reg;
    logic signed [DCW-1:0] dc_reg;
    logic signed [DCW-1:0] dr_reg;
    logic [7:0]            b1_reg;
    logic [7:0]            g1_reg;
    logic [7:0]            r1_reg;

    // stage 2: rotation products
    logic                     v2_reg;
    logic signed [PROD_W-1:0] pcc_reg;
    logic signed [PROD_W-1:0] prs_reg;
    logic signed [PROD_W-1:0] pcs_reg;
    logic signed [PROD_W-1:0] prc_reg;
    logic [7:0]               b2_reg;
    logic [7:0]               g2_reg;
    logic [7:0]               r2_reg;

    // stage 3: scaled positions
    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W-1:0] x_next;
    logic signed [SUM_W-1:0] y_next;
    logic                    v3_reg;
    logic signed [SUM_W-1:0] x_reg;
    logic signed [SUM_W-1:0] y_reg;
    logic [7:0]              b3_reg;
    logic [7:0]              g3_reg;
    logic [7:0]              r3_reg;

    // stage 4: truncation, bound check, output register
    logic signed [IW-1:0] xi;
    logic signed [IW-1:0] yi;
    logic signed [IW-1:0] side_ext;
    logic                 lands_in;
    logic                 out_valid_reg;
    logic [SW-1:0]        dst_col_reg;
    logic [SW-1:0]        dst_row_reg;
    logic                 in_frame_reg;
    logic [7:0]           blue_reg;
    logic [7:0]           green_reg;
    logic [7:0]           red_reg;

    // truncation toward zero of a value with F fraction bits
    function automatic logic signed [IW-1:0] trunc_frac(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-1:0] mag;
        logic [IW-1:0]    q;
        begin
            mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
            q   = mag[SUM_W-1:F];
            return v[SUM_W-1] ? -$signed(q) : $signed(q);
        end
    endfunction

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg  <= '0;
            width_reg  <= DW'(MAX_DIM);
            height_reg <= DW'(MAX_DIM);
            side_reg   <= SW'(SIDE_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ANGLE:  angle_reg  <= cfg_data[ANGLE_W-1:0];
                REG_WIDTH:  width_reg  <= DW'(cfg_data);
                REG_HEIGHT: height_reg <= DW'(cfg_data);
                REG_SIDE:   side_reg   <= SW'(cfg_data);
            endcase
        end
    end

    // sine and cosine, reduced modulo 360 and registered
    prm_trig_rom #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_trig (
        .clk       (clk),
        .rst_n     (rst_n),
        .angle_deg (angle_reg),
        .sin_val   (sin_val),
        .cos_val   (cos_val)
    );

    // ------------------------------------------------------------------------
    // handover: a stage loads when it is empty or its successor loads
    // ------------------------------------------------------------------------
    assign ready4   = !out_valid_reg || !out_stall;
    assign ready3   = !v3_reg || ready4;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_stall = !ready1;

    // ------------------------------------------------------------------------
    // stage 1: center offsets, dimensions clamped to MAX_DIM
    // ------------------------------------------------------------------------
    always_comb
    begin
        width_clamp  = (width_reg  > DW'(MAX_DIM)) ? DW'(MAX_DIM) : width_reg;
        height_clamp = (height_reg > DW'(MAX_DIM)) ? DW'(MAX_DIM) : height_reg;
        dc_next = $signed(DCW'(src_col)) - $signed(DCW'(width_clamp[DW-1:1]));
        dr_next = $signed(DCW'(src_row)) - $signed(DCW'(height_clamp[DW-1:1]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (ready1)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            dc_reg <= dc_next;
            dr_reg <= dr_next;
            b1_reg <= blue_in;
            g1_reg <= green_in;
            r1_reg <= red_in;
        end
    end

    // ------------------------------------------------------------------------
    // stage 2: four products of offset and trig value
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (ready2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready2 && v1_reg)
        begin
            pcc_reg <= PROD_W'(dc_reg) * PROD_W'(cos_val);
            prs_reg <= PROD_W'(dr_reg) * PROD_W'(sin_val);
            pcs_reg <= PROD_W'(dc_reg) * PROD_W'(sin_val);
            prc_reg <= PROD_W'(dr_reg) * PROD_W'(cos_val);
            b2_reg  <= b1_reg;
            g2_reg  <= g1_reg;
            r2_reg  <= r1_reg;
        end
    end

    // ------------------------------------------------------------------------
    // stage 3: frame center plus rotated offset, still scaled by 2^F
    // ------------------------------------------------------------------------
    always_comb
    begin
        base   = $signed(SUM_W'({side_reg[SW-1:1], {F{1'b0}}}));
        x_next = base + SUM_W'(pcc_reg) - SUM_W'(prs_reg);
        y_next = base + SUM_W'(pcs_reg) + SUM_W'(prc_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (ready3)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready3 && v2_reg)
        begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            b3_reg <= b2_reg;
            g3_reg <= g2_reg;
            r3_reg <= r2_reg;
        end
    end

    // ------------------------------------------------------------------------
    // stage 4: truncate toward zero, check against the frame, zero if outside
    // a value just below zero truncates to zero and counts as inside
    // ------------------------------------------------------------------------
    always_comb
    begin
        xi       = trunc_frac(x_reg);
        yi       = trunc_frac(y_reg);
        side_ext = $signed(IW'(side_reg));
        lands_in = !xi[IW-1] && !yi[IW-1] && (xi < side_ext) && (yi < side_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ready4)
            out_valid_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready4 && v3_reg)
        begin
            dst_col_reg  <= lands_in ? xi[SW-1:0] : '0;
            dst_row_reg  <= lands_in ? yi[SW-1:0] : '0;
            in_frame_reg <= lands_in;
            blue_reg     <= b3_reg;
            green_reg    <= g3_reg;
            red_reg      <= r3_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign dst_col   = dst_col_reg;
    assign dst_row   = dst_row_reg;
    assign in_frame  = in_frame_reg;
    assign blue_out  = blue_reg;
    assign green_out = green_reg;
    assign red_out   = red_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // input back-pressure only when the whole pipeline is full and held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && out_valid && out_stall))
        else $error("in_stall raised with room in the pipeline");

    // a new result only comes from a request held in the sum stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(v3_reg))
        else $error("result appeared without a request in the sum stage");

    // a result flagged inside lies within the configured frame
    a_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && in_frame) |-> (dst_col < side_reg && dst_row < side_reg))
        else $error("in-frame result outside the frame side");

    // a result flagged outside carries a zero position
    a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !in_frame) |-> (dst_col == '0 && dst_row == '0))
        else $error("dropped result carries a nonzero position");

endmodule
